@@ rtl/tcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsp_pkg
// Shared constants and types for the telnet command stream parser: protocol
// codes, result kinds, buffer sizing and the front-to-back command entry.
// ----------------------------------------------------------------------------
package tcsp_pkg;

   // Subnegotiation buffer sizing
   localparam int SUB_BUF_DEPTH = 32;
   localparam int SUB_ADDR_W    = (SUB_BUF_DEPTH > 1) ? $clog2(SUB_BUF_DEPTH) : 1;
   localparam int SUB_CNT_W     = $clog2(SUB_BUF_DEPTH + 1);

   // Command queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   // Telnet protocol codes
   localparam logic [7:0] CODE_IAC  = 8'd255;
   localparam logic [7:0] CODE_DONT = 8'd254;
   localparam logic [7:0] CODE_DO   = 8'd253;
   localparam logic [7:0] CODE_WONT = 8'd252;
   localparam logic [7:0] CODE_WILL = 8'd251;
   localparam logic [7:0] CODE_SB   = 8'd250;
   localparam logic [7:0] CODE_SE   = 8'd240;

   // Result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_OPT   = 2'd1;
   localparam logic [1:0] KIND_SUB   = 2'd2;
   localparam logic [1:0] KIND_EMPTY = 2'd3;

   typedef logic [SUB_CNT_W-1:0]  sub_cnt_type;
   typedef logic [SUB_ADDR_W-1:0] sub_addr_type;

   // One command from the front to the back. A KIND_SUB entry stands for a
   // whole buffered run of cnt bytes.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [7:0]  cmd;
      logic [7:0]  opt;
      sub_cnt_type cnt;
   } entry_type;

endpackage

@@ rtl/tcsp_ram.sv @@
// ----------------------------------------------------------------------------
// tcsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tcsp_front.sv @@
// ----------------------------------------------------------------------------
// tcsp_front
// Byte classifier: walks the IAC state machine, stores subnegotiation
// payload in the buffer RAM and pushes one command per finished transaction.
// ----------------------------------------------------------------------------
module tcsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_in_byte,
   output logic                  req_full,
   input  logic                  q_full,
   output logic                  q_push,
   output tcsp_pkg::entry_type   q_entry,
   input  logic                  run_done,
   output logic                  ram_wr_en,
   output tcsp_pkg::sub_addr_type ram_wr_addr,
   output logic [7:0]            ram_wr_data
);
   import tcsp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_IAC    = 5'b00010,
      ST_OPT    = 5'b00100,
      ST_SUB    = 5'b01000,
      ST_WAITSE = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   sub_cnt_type count_ff, count_in;
   logic [7:0]  last_cmd_ff, last_cmd_in;
   logic        busy_ff, busy_in;
   logic        accept;
   logic        is_opt_cmd;

   // Stall while the queue is full or a buffered run is still being read
   assign req_full = q_full | busy_ff;
   assign accept   = req_push & ~req_full;

   assign is_opt_cmd = (req_in_byte == CODE_DO)   || (req_in_byte == CODE_DONT) ||
                       (req_in_byte == CODE_WILL) || (req_in_byte == CODE_WONT);

   assign ram_wr_addr = count_ff[SUB_ADDR_W-1:0];
   assign ram_wr_data = req_in_byte;

   // Classify the accepted byte
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      last_cmd_in = last_cmd_ff;
      busy_in     = busy_ff;
      q_push      = 1'b0;
      q_entry     = '0;
      ram_wr_en   = 1'b0;

      if (run_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         case (state_ff)
            ST_IAC: begin
               if (req_in_byte == CODE_IAC) begin
                  q_push       = 1'b1;
                  q_entry.kind = KIND_DATA;
                  q_entry.data = CODE_IAC;
                  state_in     = ST_IDLE;
               end else begin
                  last_cmd_in = req_in_byte;
                  if (is_opt_cmd) begin
                     state_in = ST_OPT;
                  end else if (req_in_byte == CODE_SB) begin
                     count_in = '0;
                     state_in = ST_SUB;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
            ST_OPT: begin
               q_push       = 1'b1;
               q_entry.kind = KIND_OPT;
               q_entry.cmd  = last_cmd_ff;
               q_entry.opt  = req_in_byte;
               state_in     = ST_IDLE;
            end
            ST_SUB: begin
               if (req_in_byte == CODE_IAC) begin
                  state_in = ST_WAITSE;
               end else if (count_ff < SUB_CNT_W'(SUB_BUF_DEPTH)) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
               end else begin
                  // Overflow: drop the subnegotiation
                  state_in = ST_IDLE;
               end
            end
            ST_WAITSE: begin
               if (req_in_byte == CODE_SE) begin
                  q_push      = 1'b1;
                  q_entry.cmd = last_cmd_ff;
                  q_entry.cnt = count_ff;
                  if (count_ff == '0) begin
                     q_entry.kind = KIND_EMPTY;
                  end else begin
                     q_entry.kind = KIND_SUB;
                     busy_in      = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
            default: begin
               if (req_in_byte == CODE_IAC) begin
                  state_in = ST_IAC;
               end else begin
                  q_push       = 1'b1;
                  q_entry.kind = KIND_DATA;
                  q_entry.data = req_in_byte;
                  state_in     = ST_IDLE;
               end
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         last_cmd_ff <= '0;
         busy_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         last_cmd_ff <= last_cmd_in;
         busy_ff     <= busy_in;
      end
   end

   // A run in flight blocks any new command
   a_no_push_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_push)
      else $error("front pushed a command while a run was pending");

endmodule

@@ rtl/tcsp_fifo.sv @@
// ----------------------------------------------------------------------------
// tcsp_fifo
// Short command queue that decouples the front classifier from the back.
// ----------------------------------------------------------------------------
module tcsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcsp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output tcsp_pkg::entry_type head_entry,
   output logic                empty
);
   import tcsp_pkg::*;

   entry_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign empty      = (cnt_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("command queue read while empty");

endmodule

@@ rtl/tcsp_back.sv @@
// ----------------------------------------------------------------------------
// tcsp_back
// Result sequencer: takes commands from the queue, expands buffered runs
// from the RAM one byte a cycle while the output slot is free, and holds
// each result in an output register.
module tcsp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  tcsp_pkg::entry_type    q_entry,
   output logic                   q_pop,
   output tcsp_pkg::sub_addr_type ram_rd_addr,
   input  logic [7:0]             ram_rd_data,
   output logic                   run_done,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_out_byte,
   output logic [7:0]             rsp_command_code,
   output logic [7:0]             rsp_option_code,
   output logic                   rsp_last
);
   import tcsp_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   sub_cnt_type idx_ff, idx_in;
   sub_cnt_type cnt_ff, cnt_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic        out_valid_ff, out_valid_in;
   logic        slot_free;
   logic        load;
   logic        run_last;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  opt_ff, opt_in;
   logic        last_ff, last_in;

   assign slot_free = ~out_valid_ff | rsp_pop;
   assign run_last  = (SUB_CNT_W'(idx_ff + 1'b1) == cnt_ff);
   // Read one entry ahead: the address follows the next index
   assign ram_rd_addr = idx_in[SUB_ADDR_W-1:0];

   // Sequence commands and run bytes into the output register
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      run_done = 1'b0;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      code_in  = code_ff;
      opt_in   = opt_ff;
      last_in  = last_ff;

      case (state_ff)
         BK_RUN: begin
            if (slot_free) begin
               load    = 1'b1;
               kind_in = KIND_SUB;
               byte_in = ram_rd_data;
               code_in = cmd_ff;
               opt_in  = '0;
               last_in = run_last;
               idx_in  = idx_ff + 1'b1;
               if (run_last) begin
                  run_done = 1'b1;
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            if (!q_empty && slot_free) begin
               q_pop = 1'b1;
               if (q_entry.kind == KIND_SUB) begin
                  idx_in   = '0;
                  cnt_in   = q_entry.cnt;
                  cmd_in   = q_entry.cmd;
                  state_in = BK_RUN;
               end else begin
                  load    = 1'b1;
                  kind_in = q_entry.kind;
                  byte_in = q_entry.data;
                  code_in = q_entry.cmd;
                  opt_in  = q_entry.opt;
                  last_in = 1'b1;
               end
            end
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      code_ff <= code_in;
      opt_ff  <= opt_in;
      last_ff <= last_in;
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_command_code = code_ff;
   assign rsp_option_code  = opt_ff;
   assign rsp_last         = last_ff;

   a_run_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_RUN) |-> (idx_ff < cnt_ff))
      else $error("run index ran past the buffered byte count");

endmodule

@@ rtl/telnet_command_stream_parser.sv @@
// ----------------------------------------------------------------------------
// telnet_command_stream_parser
// Telnet IAC command parser: one received byte per transaction in, data,
// option and subnegotiation results out.
//
//   channel   direction  handshake       payload
//   req_      in         push / full     in_byte
//   rsp_      out        empty / pop     kind, out_byte, command_code,
//                                        option_code, last
//
// One byte is accepted per cycle while the command queue has room and no
// buffered run is pending. A completed non-empty subnegotiation holds req_full
// high after the SE byte while the run is read out of the buffer RAM one byte
// per cycle; queued commands ahead of it or a stalled rsp_pop stretch this.
// A data, option or empty result reaches the output register via the command
// queue, the first byte of a run via the queue, the run state and RAM read;
// a stalled rsp_pop backs up the queue and then raises req_full.
// Reset is synchronous; the buffer RAM is not cleared.
// ----------------------------------------------------------------------------
module telnet_command_stream_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_in_byte,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_command_code,
   output logic [7:0] rsp_option_code,
   output logic       rsp_last
);
   import tcsp_pkg::*;

   entry_type    push_entry;
   entry_type    head_entry;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   logic         run_done;
   logic         ram_wr_en;
   sub_addr_type ram_wr_addr;
   logic [7:0]   ram_wr_data;
   sub_addr_type ram_rd_addr;
   logic [7:0]   ram_rd_data;

   // Classify incoming bytes
   tcsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry),
      .run_done    (run_done),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   // Subnegotiation payload buffer
   tcsp_ram #(
      .WIDTH (8),
      .DEPTH (SUB_BUF_DEPTH),
      .AW    (SUB_ADDR_W)
   ) u_sub_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Decouple front and back
   tcsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty)
   );

   // Produce results
   tcsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_entry          (head_entry),
      .q_pop            (q_pop),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .run_done         (run_done),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_command_code (rsp_command_code),
      .rsp_option_code  (rsp_option_code),
      .rsp_last         (rsp_last)
   );

endmodule
